// ===== hdl/owbm_pkg.sv =====
// Shared types, slot timings and the CRC-8 helper for the one-wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

  localparam int TIMER_W = 9;

  localparam logic [TIMER_W-1:0] T_W0_LOW     = TIMER_W'(60);
  localparam logic [TIMER_W-1:0] T_W0_REL     = TIMER_W'(2);
  localparam logic [TIMER_W-1:0] T_W1_LOW     = TIMER_W'(2);
  localparam logic [TIMER_W-1:0] T_W1_REL     = TIMER_W'(60);
  localparam logic [TIMER_W-1:0] T_RD_LOW     = TIMER_W'(2);
  localparam logic [TIMER_W-1:0] T_RD_SAMPLE  = TIMER_W'(8);
  localparam logic [TIMER_W-1:0] T_RD_REC     = TIMER_W'(52);
  localparam logic [TIMER_W-1:0] T_RST_LOW    = TIMER_W'(480);
  localparam logic [TIMER_W-1:0] T_RST_SAMPLE = TIMER_W'(70);
  localparam logic [TIMER_W-1:0] T_RST_REC    = TIMER_W'(410);

  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_BIT_LOW  = 4'd1,
    PH_WR_REL   = 4'd2,
    PH_RD_WAIT  = 4'd3,
    PH_RD_REC   = 4'd4,
    PH_RST_LOW  = 4'd5,
    PH_RST_WAIT = 4'd6,
    PH_RST_REC  = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_PRESENCE = 2'd1,
    ST_REJECTED    = 2'd2
  } status_t;

  // Reflected Dallas CRC-8, one byte folded in.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY_REFL) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ===== hdl/one_wire_bus_master_unit.sv =====
// Top level of the one-wire bus master: phase sequencer, timers, CRC and result register.
`timescale 1ns / 1ps

// One-wire bus master with a running Dallas CRC-8.
// Input channel (in_*): every beat is either a microsecond tick carrying the
// sampled bus level, or a command (bus reset, write byte, read byte) chosen
// by in_tuser. Commands take no bus time; ticks advance the slot timers.
// Result channel (out_*): exactly one result beat per input beat, carrying
// the drive-low request for the coming microsecond, busy/done flags, status,
// the last byte read and the running CRC.
// A beat's result is registered and appears on out_* in the cycle after the
// beat is taken. Throughput: one beat per clock unless stalled; the whole
// update is one pass of combinational logic from the held state into the
// result register. in_tready is high while the result register is empty or
// is being taken in the same cycle, so a stalled receiver holds one result
// and stops the input only then; nothing is dropped or repeated.
// A command that arrives while an operation runs is rejected (done, status
// rejected) and the running operation carries on untouched.
// Reset (rst_n low, synchronous): the sequencer returns to idle, timers,
// counters, shift register, CRC and last-read byte clear, and the result
// register empties.
module one_wire_bus_master_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [owbm_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte, [8] line_level,
                                                      // [15:9] zero
  input  logic [1:0]                      in_tuser,   // [1:0] kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [owbm_pkg::OUT_DATA_W-1:0] out_tdata   // [0] drive_low, [1] busy_res,
                                                      // [2] done_res, [4:3] status,
                                                      // [12:5] read_data,
                                                      // [20:13] crc_value, [21] crc_zero,
                                                      // [23:22] zero
);

  // Sequencer state
  owbm_pkg::phase_t                  phase_r, phase_nxt;
  logic [owbm_pkg::TIMER_W-1:0]      slot_timer_r, slot_timer_nxt;
  logic [2:0]                        bit_count_r, bit_count_nxt;
  logic [7:0]                        shift_byte_r, shift_byte_nxt;
  owbm_pkg::kind_t                   operation_r, operation_nxt;
  logic                              presence_r, presence_nxt;
  logic [7:0]                        crc_r, crc_nxt;
  logic [7:0]                        last_read_r, last_read_nxt;

  // Result register
  logic                              out_valid_r;
  logic [owbm_pkg::OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  owbm_pkg::kind_t                   in_kind;
  logic [7:0]                        in_byte;
  logic                              in_line;
  logic                              in_accept;

  logic [owbm_pkg::TIMER_W-1:0]      timer_dec;
  logic                              expired;
  logic [7:0]                        fin_shift;
  logic                              done;
  owbm_pkg::status_t                 status;
  logic                              drive_low;
  logic                              busy;

  assign in_kind   = owbm_pkg::kind_t'(in_tuser);
  assign in_byte   = in_tdata[7:0];
  assign in_line   = in_tdata[8];
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign timer_dec = slot_timer_r - owbm_pkg::TIMER_W'(1);
  assign expired   = (timer_dec == '0);

  // Byte bits after the end of the current slot: writes shift the sent bit out.
  assign fin_shift = (phase_r == owbm_pkg::PH_WR_REL) ? (shift_byte_r >> 1) : shift_byte_r;

  // Next-state logic
  always_comb begin
    phase_nxt      = phase_r;
    slot_timer_nxt = slot_timer_r;
    bit_count_nxt  = bit_count_r;
    shift_byte_nxt = shift_byte_r;
    operation_nxt  = operation_r;
    presence_nxt   = presence_r;
    crc_nxt        = crc_r;
    last_read_nxt  = last_read_r;
    done           = 1'b0;
    status         = owbm_pkg::ST_OK;

    if (in_kind != owbm_pkg::KIND_TICK) begin
      if (phase_r != owbm_pkg::PH_IDLE) begin
        // Reject: leave the running operation alone
        done   = 1'b1;
        status = owbm_pkg::ST_REJECTED;
      end else if (in_kind == owbm_pkg::KIND_RESET) begin
        operation_nxt  = owbm_pkg::KIND_RESET;
        crc_nxt        = '0;
        presence_nxt   = 1'b0;
        phase_nxt      = owbm_pkg::PH_RST_LOW;
        slot_timer_nxt = owbm_pkg::T_RST_LOW;
      end else begin
        operation_nxt  = in_kind;
        bit_count_nxt  = '0;
        shift_byte_nxt = (in_kind == owbm_pkg::KIND_WRITE) ? in_byte : 8'h00;
        phase_nxt      = owbm_pkg::PH_BIT_LOW;
        if (in_kind == owbm_pkg::KIND_WRITE) begin
          slot_timer_nxt = in_byte[0] ? owbm_pkg::T_W1_LOW : owbm_pkg::T_W0_LOW;
        end else begin
          slot_timer_nxt = owbm_pkg::T_RD_LOW;
        end
      end
    end else begin
      case (phase_r)
        owbm_pkg::PH_IDLE: begin
          // Hold: ticks while idle change nothing
        end
        owbm_pkg::PH_BIT_LOW: begin
          slot_timer_nxt = timer_dec;
          if (expired) begin
            if (operation_r == owbm_pkg::KIND_WRITE) begin
              phase_nxt      = owbm_pkg::PH_WR_REL;
              slot_timer_nxt = shift_byte_r[0] ? owbm_pkg::T_W1_REL : owbm_pkg::T_W0_REL;
            end else begin
              phase_nxt      = owbm_pkg::PH_RD_WAIT;
              slot_timer_nxt = owbm_pkg::T_RD_SAMPLE;
            end
          end
        end
        owbm_pkg::PH_RD_WAIT: begin
          slot_timer_nxt = timer_dec;
          if (expired) begin
            // Sample the line into the top of the byte, LSB first overall
            shift_byte_nxt = {in_line, shift_byte_r[7:1]};
            phase_nxt      = owbm_pkg::PH_RD_REC;
            slot_timer_nxt = owbm_pkg::T_RD_REC;
          end
        end
        owbm_pkg::PH_WR_REL, owbm_pkg::PH_RD_REC: begin
          slot_timer_nxt = timer_dec;
          if (expired) begin
            shift_byte_nxt = fin_shift;
            if (bit_count_r == 3'd7) begin
              bit_count_nxt = '0;
              phase_nxt     = owbm_pkg::PH_IDLE;
              done          = 1'b1;
              if (operation_r == owbm_pkg::KIND_READ) begin
                last_read_nxt = fin_shift;
                crc_nxt       = owbm_pkg::crc8_byte(crc_r, fin_shift);
              end
            end else begin
              bit_count_nxt = bit_count_r + 3'd1;
              phase_nxt     = owbm_pkg::PH_BIT_LOW;
              if (operation_r == owbm_pkg::KIND_WRITE) begin
                slot_timer_nxt = fin_shift[0] ? owbm_pkg::T_W1_LOW : owbm_pkg::T_W0_LOW;
              end else begin
                slot_timer_nxt = owbm_pkg::T_RD_LOW;
              end
            end
          end
        end
        owbm_pkg::PH_RST_LOW: begin
          slot_timer_nxt = timer_dec;
          if (expired) begin
            phase_nxt      = owbm_pkg::PH_RST_WAIT;
            slot_timer_nxt = owbm_pkg::T_RST_SAMPLE;
          end
        end
        owbm_pkg::PH_RST_WAIT: begin
          slot_timer_nxt = timer_dec;
          if (expired) begin
            // A device answering pulls the line low here
            presence_nxt   = !in_line;
            phase_nxt      = owbm_pkg::PH_RST_REC;
            slot_timer_nxt = owbm_pkg::T_RST_REC;
          end
        end
        owbm_pkg::PH_RST_REC: begin
          slot_timer_nxt = timer_dec;
          if (expired) begin
            done      = 1'b1;
            status    = (presence_r && in_line) ? owbm_pkg::ST_OK : owbm_pkg::ST_NO_PRESENCE;
            phase_nxt = owbm_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_nxt = owbm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Output logic: flags follow the phase after this beat
  always_comb begin
    drive_low    = (phase_nxt == owbm_pkg::PH_BIT_LOW) || (phase_nxt == owbm_pkg::PH_RST_LOW);
    busy         = (phase_nxt != owbm_pkg::PH_IDLE);
    out_data_nxt = {2'b00, (crc_nxt == 8'h00), crc_nxt, last_read_nxt,
                    status, done, busy, drive_low};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= owbm_pkg::PH_IDLE;
      slot_timer_r <= '0;
      bit_count_r  <= '0;
      shift_byte_r <= '0;
      operation_r  <= owbm_pkg::KIND_TICK;
      presence_r   <= 1'b0;
      crc_r        <= '0;
      last_read_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r      <= phase_nxt;
        slot_timer_r <= slot_timer_nxt;
        bit_count_r  <= bit_count_nxt;
        shift_byte_r <= shift_byte_nxt;
        operation_r  <= operation_nxt;
        presence_r   <= presence_nxt;
        crc_r        <= crc_nxt;
        last_read_r  <= last_read_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // Result payload: load on every accepted beat
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/owbm_checker.sv =====
// Port-level checker for the one-wire bus master, bound to the top level.
`timescale 1ns / 1ps

module owbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // The result register empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid just after reset");

  // The zero flag tracks the CRC field
  a_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[21] == (out_tdata[20:13] == 8'h00)))
    else $error("crc_zero disagrees with crc_value");

  // A non-ok status comes only with done
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[4:3] != 2'd0) |-> out_tdata[2])
    else $error("status set without done");

  // The bus is pulled low only during an operation
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("drive_low while not busy");

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (.*);
